@@ rtl/core/hbd_pkg.sv @@
// Shared constants, command and status types, and coefficient table for the halfband decimator.
package hbd_pkg;

  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int COEFF_FRAC_BITS_DEF = 17;

  localparam int RING_DEPTH    = 31;
  localparam int RING_AW       = $clog2(RING_DEPTH);
  localparam int PAIR_COUNT    = 8;
  localparam int CENTRE_OFFSET = 15;
  // The centre tap runs as a ninth step that reads offset 15 on both ports.
  localparam int STEP_COUNT    = PAIR_COUNT + 1;
  localparam int STEP_W        = $clog2(STEP_COUNT);
  localparam logic [STEP_W-1:0] CENTRE_STEP = STEP_W'(PAIR_COUNT);
  localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(STEP_COUNT - 1);

  // Coefficient magnitudes scaled by 2^32, and their signs.
  localparam logic [31:0] PAIR_MAG32 [PAIR_COUNT] = '{
    32'd7314973,   32'd12636169,  32'd28952322,  32'd60630795,
    32'd115227112, 32'd211219857, 32'd417021064, 32'd1357770476
  };
  localparam logic [PAIR_COUNT-1:0] PAIR_NEG = 8'b0101_0101;

  typedef struct packed {
    logic              wr_en;    // write the accepted sample into the ring
    logic              acc_clr;  // clear the accumulator for a new result
    logic              rd_en;    // issue the ring reads for one step
    logic [STEP_W-1:0] rd_step;  // step index of the issued reads
    logic              rd_last;  // the issued step is the last one
    logic              load_out; // load the rounded result into the output register
  } hbd_cmd_t;

  typedef struct packed {
    logic acc_last; // the last product enters the accumulator this cycle
  } hbd_status_t;

  // Coefficient for one step, rounded half away from zero to frac_bits fraction bits.
  // The centre step carries half of the centre weight because it sees the sample twice.
  function automatic logic signed [31:0] coeff_value(input logic [STEP_W-1:0] step,
                                                     input int frac_bits);
    logic [32:0] mag;
    logic [32:0] q;
    logic [31:0] res;
    mag = 33'(PAIR_MAG32[3'(step)]);
    q   = (mag + (33'd1 << (31 - frac_bits))) >> (32 - frac_bits);
    if (step >= CENTRE_STEP) begin
      res = 32'd1 << (frac_bits - 2);
    end else if (PAIR_NEG[3'(step)]) begin
      res = -q[31:0];
    end else begin
      res = q[31:0];
    end
    return $signed(res);
  endfunction

endpackage

@@ rtl/core/hbd_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
module hbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a_r,
  output logic [WIDTH-1:0]         rd_data_b_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

endmodule

@@ rtl/core/hbd_ctrl.sv @@
// Controller state machine: input and output handshakes and step sequencing.
module hbd_ctrl
  import hbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  hbd_status_t status,
  output hbd_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_ROUND = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_xfer;
  logic              out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    phase_nxt    = phase_r;
    cmd          = '0;
    cmd.rd_step  = step_r;
    cmd.rd_last  = (step_r == LAST_STEP);
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.wr_en = 1'b1;
          phase_nxt = ~phase_r;
          // A transfer that sets the phase bit produces a result.
          if (!phase_r) begin
            cmd.acc_clr = 1'b1;
            step_nxt    = '0;
            state_nxt   = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd.rd_en = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_DRAIN: begin
        if (status.acc_last) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/hbd_dpath.sv @@
// Datapath: sample ring, pair adder, shared multiplier, accumulator, rounding and saturation.
module hbd_dpath
  import hbd_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hbd_cmd_t                       cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output hbd_status_t                    status,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample
);

  localparam int SUM_W = SAMPLE_WIDTH + 1;
  localparam int CW    = COEFF_FRAC_BITS + 1;
  localparam int PW    = SUM_W + CW;
  localparam int ACC_W = SAMPLE_WIDTH + COEFF_FRAC_BITS + 3;
  localparam int SH_W  = ACC_W - COEFF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND_ADD = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
  localparam logic signed [SH_W-1:0]  SAT_HI  = SH_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [SH_W-1:0]  SAT_LO  = -SAT_HI - SH_W'(1);
  localparam logic [RING_AW-1:0]      RING_TOP = RING_AW'(RING_DEPTH - 1);

  logic [RING_AW-1:0]      wp_r;
  logic [RING_AW-1:0]      base_r;
  logic [RING_DEPTH-1:0]   vld_r;
  logic [RING_AW-1:0]      back_e, back_l;
  logic [RING_AW-1:0]      addr_e, addr_l;
  logic [SAMPLE_WIDTH-1:0] rd_e, rd_l;

  logic                    s1_vld_r, s1_last_r, ve_r, vl_r;
  logic [STEP_W-1:0]       s1_step_r;
  logic                    s2_vld_r, s2_last_r;
  logic                    s3_vld_r, s3_last_r;
  logic signed [SUM_W-1:0] ext_e, ext_l;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [31:0]      coef_full;
  logic signed [CW-1:0]    coef_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] rnd;
  logic signed [SH_W-1:0]  q;
  logic signed [SAMPLE_WIDTH-1:0] sat;
  logic signed [SAMPLE_WIDTH-1:0] out_r;

  // Position that lies a given number of samples back from the newest one.
  function automatic logic [RING_AW-1:0] ring_pos(input logic [RING_AW-1:0] base,
                                                  input logic [RING_AW-1:0] back);
    logic [RING_AW:0] t;
    t = {1'b0, base} + (RING_AW+1)'(RING_DEPTH) - {1'b0, back};
    if (t >= (RING_AW+1)'(RING_DEPTH)) begin
      t = t - (RING_AW+1)'(RING_DEPTH);
    end
    return t[RING_AW-1:0];
  endfunction

  always_comb begin
    if (cmd.rd_step == CENTRE_STEP) begin
      back_e = RING_AW'(CENTRE_OFFSET);
      back_l = RING_AW'(CENTRE_OFFSET);
    end else begin
      back_e = {cmd.rd_step[RING_AW-2:0], 1'b0};
      back_l = RING_TOP - {cmd.rd_step[RING_AW-2:0], 1'b0};
    end
  end

  assign addr_e = ring_pos(base_r, back_e);
  assign addr_l = ring_pos(base_r, back_l);

  hbd_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk        (clk),
    .wr_en      (cmd.wr_en),
    .wr_addr    (wp_r),
    .wr_data    (in_sample),
    .rd_en      (cmd.rd_en),
    .rd_addr_a  (addr_e),
    .rd_addr_b  (addr_l),
    .rd_data_a_r(rd_e),
    .rd_data_b_r(rd_l)
  );

  // Entries never written since reset read as zero.
  assign ext_e = ve_r ? $signed({rd_e[SAMPLE_WIDTH-1], rd_e}) : '0;
  assign ext_l = vl_r ? $signed({rd_l[SAMPLE_WIDTH-1], rd_l}) : '0;
  assign coef_full = coeff_value(s1_step_r, COEFF_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      vld_r     <= '0;
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s2_vld_r  <= 1'b0;
      s2_last_r <= 1'b0;
      s3_vld_r  <= 1'b0;
      s3_last_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        vld_r[wp_r] <= 1'b1;
        wp_r        <= (wp_r == RING_TOP) ? '0 : wp_r + RING_AW'(1);
      end
      s1_vld_r  <= cmd.rd_en;
      s1_last_r <= cmd.rd_en && cmd.rd_last;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
      s3_vld_r  <= s2_vld_r;
      s3_last_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      base_r <= wp_r;
    end
    if (cmd.rd_en) begin
      ve_r      <= vld_r[addr_e];
      vl_r      <= vld_r[addr_l];
      s1_step_r <= cmd.rd_step;
    end
    sum_r  <= ext_e + ext_l;
    coef_r <= $signed(coef_full[CW-1:0]);
    prod_r <= sum_r * coef_r;
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (s3_vld_r) begin
      acc_r <= acc_r + {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};
    end
    if (cmd.load_out) begin
      out_r <= sat;
    end
  end

  // Round half up, drop the fraction bits, then clamp to the sample range.
  assign rnd = acc_r + RND_ADD;
  assign q   = rnd[ACC_W-1:COEFF_FRAC_BITS];

  always_comb begin
    if (q > SAT_HI) begin
      sat = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (q < SAT_LO) begin
      sat = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat = q[SAMPLE_WIDTH-1:0];
    end
  end

  assign status.acc_last = s3_vld_r && s3_last_r;
  assign out_sample      = out_r;

endmodule

@@ rtl/core/halfband_decimator_2to1.sv @@
// Top level of the 31-tap halfband two-to-one decimator.
// Every input transfer writes one Q1.15 sample into a 31-entry ring of past samples, and
// every second transfer (the first, third, fifth and so on after reset) produces one
// filtered result: half the centre sample plus eight symmetric coefficient pairs, rounded
// half up and saturated to the sample width. A transfer that produces no result leaves
// the block idle and ready for the next sample. A transfer that produces a result keeps
// the input stalled while the block runs nine steps through the dual-read ring memory
// (eight pairs and the centre tap, one step a cycle into the single shared multiplier),
// drains the pair adder, multiplier and accumulator pipeline, and rounds the result into
// the output register. The output register holds a finished result while the source
// keeps sending, so a stalled result channel only delays the next result's final step.
// The ring clears at reset through a valid bit per entry, so no clearing pass is needed.
module halfband_decimator_2to1
  import hbd_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_audio_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_sample
);

  hbd_cmd_t    cmd;
  hbd_status_t status;

  // The controller owns both handshakes, the phase bit and the step counter.
  hbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the ring, the multiply-accumulate pipeline and the result register.
  hbd_dpath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_sample (in_audio_sample),
    .status    (status),
    .out_sample(out_filtered_sample)
  );

endmodule

@@ rtl/core/hbd_checker.sv @@
// Port-level assertions for the halfband decimator, bound to the top level.
module hbd_checker
  import hbd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] out_filtered_sample
);

  logic       phase_r;
  logic [1:0] owed_r;
  logic       in_xfer, out_xfer, emit;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign emit     = in_xfer && !phase_r;

  // Track the phase and the number of results owed but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      owed_r  <= '0;
    end else begin
      if (in_xfer) begin
        phase_r <= ~phase_r;
      end
      owed_r <= owed_r + 2'(emit) - 2'(out_xfer);
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered_sample))
    else $error("stalled result changed or dropped");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> in_stall)
    else $error("input not stalled while a result is computed");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> owed_r != 2'd0)
    else $error("result shown without an owed input");

endmodule

bind halfband_decimator_2to1 hbd_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_hbd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_filtered_sample(out_filtered_sample)
);
